// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL.
// Needs signals clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while in reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/fpmd_pkg.sv
// Types and constants of the fixed-point multiply/divide unit.
// No dependencies.
package fpmd_pkg;

	localparam int unsigned STEPS     = 32;
	localparam int unsigned MUL_STEPS = 16;

	typedef enum logic {
		MODE_MUL = 1'b0,
		MODE_DIV = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_OVF = 2'd1,
		ST_DZ  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		BOOTH_Z0  = 3'd0,
		BOOTH_P1A = 3'd1,
		BOOTH_P1B = 3'd2,
		BOOTH_P2  = 3'd3,
		BOOTH_N2  = 3'd4,
		BOOTH_N1A = 3'd5,
		BOOTH_N1B = 3'd6,
		BOOTH_Z1  = 3'd7
	} booth_t;

	typedef struct packed {
		logic               mode;
		logic signed [63:0] operand_a;
		logic signed [31:0] operand_b;
	} fpmd_in_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic [1:0]         status;
	} fpmd_out_t;

	typedef struct packed {
		mode_t       mode;
		status_t     status;
		logic        neg;
		logic [63:0] acc;
		logic [31:0] op;
		logic [32:0] ext;
		logic [31:0] q;
	} fpmd_work_t;

endpackage

// File: hdl/fpmd_pre.sv
// Input stage: operand checks, magnitudes and initial accumulator.
// Depends on fpmd_pkg.
module fpmd_pre #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  fpmd_pkg::fpmd_in_t  din,
	output logic                out_valid,
	output fpmd_pkg::fpmd_work_t dout
);
	import fpmd_pkg::*;

	logic               valid_q;
	fpmd_work_t         work_q;
	fpmd_work_t         work_d;
	logic [63:0]        mag_a;
	logic [31:0]        mag_b;
	logic signed [63:0] top;
	logic               sa;
	logic               sb;

	always_comb begin
		sa    = din.operand_a[63];
		sb    = din.operand_b[31];
		mag_a = sa ? 64'(-din.operand_a) : din.operand_a;
		mag_b = sb ? 32'(-din.operand_b) : din.operand_b;
		top   = din.operand_a >>> (64 - FRAC_BITS);
		work_d = '0;
		if (din.mode == MODE_MUL) begin
			work_d.mode   = MODE_MUL;
			work_d.status = (din.operand_a[31] ^ din.operand_a[30]) ? ST_OVF : ST_OK;
			work_d.op     = din.operand_a[31:0];
			work_d.ext    = {din.operand_b, 1'b0};
		end else begin
			work_d.mode = MODE_DIV;
			if (din.operand_b == '0)
				work_d.status = ST_DZ;
			else if (top != '0 && top != '1)
				work_d.status = ST_OVF;
			else
				work_d.status = ST_OK;
			work_d.neg = sa ^ sb;
			work_d.acc = mag_a << FRAC_BITS;
			work_d.op  = mag_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			work_q <= work_d;
		end
	end

	assign out_valid = valid_q;
	assign dout      = work_q;

endmodule

// File: hdl/fpmd_cell.sv
// One step cell: a Booth radix-4 step or a non-restoring divide step.
// Depends on fpmd_pkg.
module fpmd_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  fpmd_pkg::fpmd_work_t din,
	output logic                 out_valid,
	output fpmd_pkg::fpmd_work_t dout
);
	import fpmd_pkg::*;

	logic        valid_q;
	fpmd_work_t  work_q;
	fpmd_work_t  work_d;
	logic [31:0] addend;
	logic [31:0] hi;

	always_comb begin
		work_d = din;
		addend = '0;
		hi     = '0;
		if (din.mode == MODE_MUL) begin
			if (IDX < MUL_STEPS) begin
				case (booth_t'(din.ext[2:0]))
					BOOTH_P1A, BOOTH_P1B: addend = din.op;
					BOOTH_P2:             addend = {din.op[30:0], 1'b0};
					BOOTH_N2:             addend = 32'(-{din.op[30:0], 1'b0});
					BOOTH_N1A, BOOTH_N1B: addend = 32'(-din.op);
					default:              addend = '0;
				endcase
				hi = din.acc[63:32] + addend;
				work_d.acc = {hi[31], hi[31], hi, din.acc[31:2]};
				work_d.ext = {2'b00, din.ext[32:2]};
			end
		end else begin
			if (!din.acc[63]) begin
				hi = din.acc[62:31] - din.op;
				work_d.q = {din.q[30:0], 1'b1};
			end else begin
				hi = din.acc[62:31] + din.op;
				work_d.q = {din.q[30:0], 1'b0};
			end
			work_d.acc = {hi, din.acc[30:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			work_q <= work_d;
		end
	end

	assign out_valid = valid_q;
	assign dout      = work_q;

endmodule

// File: hdl/fpmd_post.sv
// Output stage: product scaling, quotient correction and result register.
// Depends on fpmd_pkg.
module fpmd_post #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  fpmd_pkg::fpmd_work_t din,
	output logic                 out_valid,
	output fpmd_pkg::fpmd_out_t  dout
);
	import fpmd_pkg::*;

	logic        valid_q;
	fpmd_out_t   res_q;
	fpmd_out_t   res_d;
	logic [31:0] q1;
	logic [31:0] q2;
	logic [31:0] q3;

	always_comb begin
		q1 = {din.q[30:0], 1'b1};
		q2 = (din.acc[63] && !q1[31]) ? q1 - 32'd1 : q1;
		q3 = din.neg ? 32'(-q2) : q2;
		res_d.status = din.status;
		if (din.mode == MODE_MUL)
			res_d.value = $signed(din.acc) >>> FRAC_BITS;
		else if (din.status != ST_OK)
			res_d.value = '0;
		else
			res_d.value = {{32{q3[31]}}, q3};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			res_q <= res_d;
		end
	end

	assign out_valid = valid_q;
	assign dout      = res_q;

endmodule

// File: hdl/fixed_point_mul_div_unit.sv
// Signed fixed-point multiply/divide unit, top level.
// Depends on fpmd_pkg, fpmd_pre, fpmd_cell, fpmd_post, assert_macros.svh.
//
// Usage:
// - cmd channel (cmd_valid, cmd_stall, cmd) carries mode and operands; a
//   transaction completes when cmd_valid is high and cmd_stall is low.
// - res channel (res_valid, res_stall, res) returns value and status, one
//   transaction per command, in command order.
// - The input stage loads at cmd acceptance; the transaction then passes a
//   row of 32 step cells and one output register before res_valid rises.
// - Throughput is one transaction per cycle while res_stall is low. Each cell does one divide step
//   (32 in all) or one Booth step (first 16 cells) per cycle.
// - When res_stall holds, the output register keeps its transaction; stages
//   behind it still move forward into empty slots, and cmd_stall rises only
//   when the input stage is full and cannot advance.
// - Reset clears all stage valid bits; the unit is empty afterwards and
//   accepts a command as soon as reset is released.
module fixed_point_mul_div_unit #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  fpmd_pkg::fpmd_in_t  cmd,
	output logic                res_valid,
	input  logic                res_stall,
	output fpmd_pkg::fpmd_out_t res
);
	import fpmd_pkg::*;

	localparam int unsigned NST = STEPS + 2;

	logic       v   [NST];
	logic       mv  [NST];
	fpmd_work_t w   [STEPS + 1];

	always_comb begin
		mv[NST - 1] = !v[NST - 1] || !res_stall;
		for (int k = NST - 2; k >= 0; k--)
			mv[k] = !v[k] || mv[k + 1];
	end

	assign cmd_stall = !mv[0];
	assign res_valid = v[NST - 1];

	fpmd_pre #(.FRAC_BITS(FRAC_BITS)) u_pre (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (mv[0]),
		.in_valid (cmd_valid),
		.din      (cmd),
		.out_valid(v[0]),
		.dout     (w[0])
	);

	for (genvar k = 0; k < STEPS; k++) begin : g_cell
		fpmd_cell #(.IDX(k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (mv[k + 1]),
			.in_valid (v[k]),
			.din      (w[k]),
			.out_valid(v[k + 1]),
			.dout     (w[k + 1])
		);
	end

	fpmd_post #(.FRAC_BITS(FRAC_BITS)) u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (mv[NST - 1]),
		.in_valid (v[STEPS]),
		.din      (w[STEPS]),
		.out_valid(v[NST - 1]),
		.dout     (res)
	);

`include "assert_macros.svh"

	`ASSERT_CLK(a_cmd_load, cmd_valid && !cmd_stall |=> v[0], "accepted command not loaded")
	`ASSERT_ALWAYS(a_stall_full, cmd_stall |-> v[0], "cmd stalled with empty input stage")
	`ASSERT_CLK(a_dz_zero, res_valid && res.status == ST_DZ |-> res.value == '0, "divide by zero value not zero")
	`ASSERT_CLK(a_status_code, res_valid |-> (res.status == ST_OK || res.status == ST_OVF || res.status == ST_DZ), "bad status code")

endmodule
